>>> src/lsgc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the laser stripe gray centroid block.
// No dependencies; the design files use it by scoped names, the test files import it.
package lsgc_pkg;

	localparam int PIX_W      = 8;
	localparam int ROW_W      = 11;
	localparam int COL_W      = 11;
	localparam int PROD_W     = ROW_W + PIX_W;
	localparam int WACC_W     = 31;
	localparam int IACC_W     = 20;
	localparam int CENTER_W   = 19;
	localparam int SUMTHR_W   = 19;
	localparam int ROI_POS_W  = 11;
	localparam int ROI_SIZE_W = 12;
	localparam int LIM_W      = 13;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 19;

	localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_THR  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SUM_THR    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ROI_LEFT   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ROI_TOP    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ROI_WIDTH  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_ROI_HEIGHT = 3'd5;

	// controller to datapath
	typedef struct packed {
		logic take;      // pixel channel open
		logic clr_acc;   // column closed: clear accumulators
		logic div_start; // load divider with accumulators
		logic out_load;  // move quotient into output register
	} lsgc_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic sum_pass;  // intensity sum above sum threshold
		logic div_busy;
		logic out_free;  // output register empty or being taken
	} lsgc_stat_t;

endpackage

>>> src/lsgc_ifs.sv
`timescale 1ns / 1ps
// Valid/ready channels of the laser stripe gray centroid block: pixels in,
// centers out, configuration writes. Depends on lsgc_pkg for field widths.
interface lsgc_pix_if;
	logic                          valid;
	logic                          ready;
	logic [lsgc_pkg::PIX_W-1:0]    pixel_value;
	logic [lsgc_pkg::ROW_W-1:0]    row_index;
	logic [lsgc_pkg::COL_W-1:0]    column_index;
	logic                          column_end;
	modport source (output valid, pixel_value, row_index, column_index, column_end,
		input ready);
	modport sink (input valid, pixel_value, row_index, column_index, column_end,
		output ready);
endinterface

interface lsgc_res_if;
	logic                            valid;
	logic                            ready;
	logic [lsgc_pkg::COL_W-1:0]      out_column;
	logic [lsgc_pkg::CENTER_W-1:0]   center_row_fixed;
	modport source (output valid, out_column, center_row_fixed, input ready);
	modport sink (input valid, out_column, center_row_fixed, output ready);
endinterface

interface lsgc_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [lsgc_pkg::CFG_IDX_W-1:0]    index;
	logic [lsgc_pkg::CFG_DATA_W-1:0]   data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> src/lsgc_ctrl.sv
`timescale 1ns / 1ps
// Column sequencer: opens the pixel channel, closes a column on its end mark,
// runs the divider and hands the center to the output register. Uses lsgc_pkg.
module lsgc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pix_valid,
	input  logic                 pix_column_end,
	input  lsgc_pkg::lsgc_stat_t stat,
	output lsgc_pkg::lsgc_cmd_t  cmd
);

	typedef enum logic [4:0] {
		ST_RUN   = 5'b00001,
		ST_ACC   = 5'b00010,
		ST_CHECK = 5'b00100,
		ST_DIV   = 5'b01000,
		ST_EMIT  = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		unique case (state_q)
			ST_RUN: begin
				cmd.take = 1'b1;
				if (pix_valid && pix_column_end) begin
					state_d = ST_ACC;
				end
			end
			// last pixel of the column is being added in this cycle
			ST_ACC: begin
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				cmd.clr_acc = 1'b1;
				if (stat.sum_pass) begin
					cmd.div_start = 1'b1;
					state_d       = ST_DIV;
				end else begin
					state_d = ST_RUN;
				end
			end
			ST_DIV: begin
				if (!stat.div_busy) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_RUN;
				end
			end
			default: begin
				state_d = ST_RUN;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> src/lsgc_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle: (weighted << FRACTION_BITS)
// / intensity, saturated to the center width. Uses lsgc_pkg.
module lsgc_div #(
	parameter int FRACTION_BITS = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [lsgc_pkg::WACC_W-1:0]     weighted,
	input  logic [lsgc_pkg::IACC_W-1:0]     intensity,
	output logic                            busy,
	output logic [lsgc_pkg::CENTER_W-1:0]   quotient
);

	localparam int NUM_W = lsgc_pkg::WACC_W + FRACTION_BITS;
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic                          busy_q;
	logic [CNT_W-1:0]              cnt_q;
	logic [NUM_W-1:0]              quo_q;
	logic [lsgc_pkg::IACC_W-1:0]   rem_q;
	logic [lsgc_pkg::IACC_W-1:0]   den_q;
	logic [lsgc_pkg::IACC_W:0]     trial;
	logic                          fits;

	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= NUM_W'(weighted) << FRACTION_BITS;
			rem_q <= '0;
			den_q <= intensity;
		end else if (busy_q) begin
			// shift the next numerator bit in, subtract when the divisor fits
			quo_q <= {quo_q[NUM_W-2:0], fits};
			if (fits) begin
				rem_q <= lsgc_pkg::IACC_W'(trial - {1'b0, den_q});
			end else begin
				rem_q <= trial[lsgc_pkg::IACC_W-1:0];
			end
		end
	end

	assign busy     = busy_q;
	assign quotient = (|quo_q[NUM_W-1:lsgc_pkg::CENTER_W]) ? '1
		: quo_q[lsgc_pkg::CENTER_W-1:0];

endmodule

>>> src/lsgc_dp.sv
`timescale 1ns / 1ps
// Datapath: configuration registers, region test, product stage, saturating
// accumulators, divider and output register. Uses lsgc_pkg and lsgc_div.
module lsgc_dp #(
	parameter int IMAGE_ROWS    = 2048,
	parameter int IMAGE_COLS    = 2048,
	parameter int FRACTION_BITS = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  lsgc_pkg::lsgc_cmd_t               cmd,
	output lsgc_pkg::lsgc_stat_t              stat,
	input  logic                              cfg_valid,
	input  logic [lsgc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lsgc_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              pix_valid,
	input  logic [lsgc_pkg::PIX_W-1:0]        pixel_value,
	input  logic [lsgc_pkg::ROW_W-1:0]        row_index,
	input  logic [lsgc_pkg::COL_W-1:0]        column_index,
	input  logic                              res_ready,
	output logic                              res_valid,
	output logic [lsgc_pkg::COL_W-1:0]        out_column,
	output logic [lsgc_pkg::CENTER_W-1:0]     center_row_fixed
);

	localparam int LW = lsgc_pkg::LIM_W;

	logic [lsgc_pkg::PIX_W-1:0]       pix_thr_q;
	logic [lsgc_pkg::SUMTHR_W-1:0]    sum_thr_q;
	logic [lsgc_pkg::ROI_POS_W-1:0]   roi_left_q;
	logic [lsgc_pkg::ROI_POS_W-1:0]   roi_top_q;
	logic [lsgc_pkg::ROI_SIZE_W-1:0]  roi_width_q;
	logic [lsgc_pkg::ROI_SIZE_W-1:0]  roi_height_q;

	logic                             accept;
	logic                             in_image;
	logic                             in_roi;
	logic                             hit;
	logic                             valid_s1;
	logic                             hit_s1;
	logic [lsgc_pkg::PROD_W-1:0]      prod_s1;
	logic [lsgc_pkg::PIX_W-1:0]       value_s1;
	logic [lsgc_pkg::COL_W-1:0]       col_s1;

	logic [lsgc_pkg::WACC_W-1:0]      wacc_q;
	logic [lsgc_pkg::IACC_W-1:0]      iacc_q;
	logic [lsgc_pkg::WACC_W:0]        wsum;
	logic [lsgc_pkg::IACC_W:0]        isum;

	logic                             div_busy;
	logic [lsgc_pkg::CENTER_W-1:0]    quotient;
	logic                             out_valid_q;
	logic [lsgc_pkg::COL_W-1:0]       out_col_q;
	logic [lsgc_pkg::CENTER_W-1:0]    out_center_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_thr_q    <= '0;
			sum_thr_q    <= '0;
			roi_left_q   <= '0;
			roi_top_q    <= '0;
			roi_width_q  <= '0;
			roi_height_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				lsgc_pkg::CFG_PIXEL_THR:  pix_thr_q    <= cfg_data[lsgc_pkg::PIX_W-1:0];
				lsgc_pkg::CFG_SUM_THR:    sum_thr_q    <= cfg_data[lsgc_pkg::SUMTHR_W-1:0];
				lsgc_pkg::CFG_ROI_LEFT:   roi_left_q   <= cfg_data[lsgc_pkg::ROI_POS_W-1:0];
				lsgc_pkg::CFG_ROI_TOP:    roi_top_q    <= cfg_data[lsgc_pkg::ROI_POS_W-1:0];
				lsgc_pkg::CFG_ROI_WIDTH:  roi_width_q  <= cfg_data[lsgc_pkg::ROI_SIZE_W-1:0];
				lsgc_pkg::CFG_ROI_HEIGHT: roi_height_q <= cfg_data[lsgc_pkg::ROI_SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// region test: clip to image, then a zero-sized region means whole image
	assign accept   = pix_valid && cmd.take;
	assign in_image = (LW'(row_index) < LW'(IMAGE_ROWS)) && (LW'(column_index) < LW'(IMAGE_COLS));
	assign in_roi   = (roi_width_q == '0) || (roi_height_q == '0) ||
		((column_index >= roi_left_q) &&
		 (LW'(column_index) < LW'(roi_left_q) + LW'(roi_width_q)) &&
		 (row_index >= roi_top_q) &&
		 (LW'(row_index) < LW'(roi_top_q) + LW'(roi_height_q)));
	assign hit      = in_image && in_roi && (pixel_value >= pix_thr_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hit_s1   <= hit;
			prod_s1  <= row_index * pixel_value;
			value_s1 <= pixel_value;
			col_s1   <= column_index;
		end
	end

	assign wsum = {1'b0, wacc_q} + (lsgc_pkg::WACC_W + 1)'(prod_s1);
	assign isum = {1'b0, iacc_q} + (lsgc_pkg::IACC_W + 1)'(value_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wacc_q <= '0;
			iacc_q <= '0;
		end else if (cmd.clr_acc) begin
			wacc_q <= '0;
			iacc_q <= '0;
		end else if (valid_s1 && hit_s1) begin
			wacc_q <= wsum[lsgc_pkg::WACC_W] ? '1 : wsum[lsgc_pkg::WACC_W-1:0];
			iacc_q <= isum[lsgc_pkg::IACC_W] ? '1 : isum[lsgc_pkg::IACC_W-1:0];
		end
	end

	lsgc_div #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.weighted (wacc_q),
		.intensity(iacc_q),
		.busy     (div_busy),
		.quotient (quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_col_q    <= col_s1;
			out_center_q <= quotient;
		end
	end

	assign stat.sum_pass = iacc_q > {1'b0, sum_thr_q};
	assign stat.div_busy = div_busy;
	assign stat.out_free = !out_valid_q || res_ready;

	assign res_valid        = out_valid_q;
	assign out_column       = out_col_q;
	assign center_row_fixed = out_center_q;

endmodule

>>> src/laser_stripe_gray_centroid.sv
`timescale 1ns / 1ps
// Laser stripe center extraction by gray centroid.
// Channels: pix (sink) takes one gray pixel per transfer with its row, column
// and end-of-column mark, in column-major order; res (source) gives the column
// and its centroid row with FRACTION_BITS fraction bits; cfg (sink) writes one
// register per transfer and is always ready (indexes beyond the list are ignored).
// Throughput: one pixel per cycle inside a column. After the transfer that
// carries the column end, pix.ready stays low while the column is closed in ST_ACC
// and ST_CHECK; when the sum passes, the divider then runs one quotient bit per
// cycle over 31 + FRACTION_BITS bits (ST_DIV) and the quotient moves into the
// output register (ST_EMIT) before pix opens again, while a column that fails
// the sum test gives no transfer and reopens pix after ST_CHECK.
// The output register holds one center; if res stalls, the next center waits
// in the divider and pix stays closed until the register frees.
// Reset clears all configuration registers, both accumulators and the output valid.
// Lookup of the helper modules: lsgc_ctrl, lsgc_dp, lsgc_div, lsgc_pkg, lsgc_ifs.
module laser_stripe_gray_centroid #(
	parameter int IMAGE_ROWS    = 2048,
	parameter int IMAGE_COLS    = 2048,
	parameter int FRACTION_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	lsgc_pix_if.sink    pix,
	lsgc_res_if.source  res,
	lsgc_cfg_if.sink    cfg
);

	lsgc_pkg::lsgc_cmd_t  cmd;
	lsgc_pkg::lsgc_stat_t stat;

	assign pix.ready = cmd.take;
	assign cfg.ready = 1'b1;

	lsgc_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.pix_valid     (pix.valid),
		.pix_column_end(pix.column_end),
		.stat          (stat),
		.cmd           (cmd)
	);

	lsgc_dp #(
		.IMAGE_ROWS   (IMAGE_ROWS),
		.IMAGE_COLS   (IMAGE_COLS),
		.FRACTION_BITS(FRACTION_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.cfg_valid       (cfg.valid),
		.cfg_index       (cfg.index),
		.cfg_data        (cfg.data),
		.pix_valid       (pix.valid),
		.pixel_value     (pix.pixel_value),
		.row_index       (pix.row_index),
		.column_index    (pix.column_index),
		.res_ready       (res.ready),
		.res_valid       (res.valid),
		.out_column      (res.out_column),
		.center_row_fixed(res.center_row_fixed)
	);

	a_div_needs_sum: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> stat.sum_pass)
		else $error("divider started on a column below the sum threshold");

	a_closed_while_div: assert property (@(posedge clk) disable iff (!arst_n)
		stat.div_busy |-> !pix.ready)
		else $error("pixel channel open while the divider runs");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!res.valid || res.ready))
		else $error("output register loaded over a pending center");

	a_clear_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		(pix.valid && pix.ready && pix.column_end) |=> ##1 cmd.clr_acc)
		else $error("accumulators not cleared after column end");

endmodule

>>> verif/laser_stripe_gray_centroid_checker.sv
`timescale 1ns / 1ps
// Checker for the laser stripe gray centroid block: watches the pixel, center and
// register channels, predicts each column center and compares it field by field.
// Depends on lsgc_pkg and the channel interfaces in lsgc_ifs.
module laser_stripe_gray_centroid_checker #(
	parameter int IMAGE_ROWS    = 2048,
	parameter int IMAGE_COLS    = 2048,
	parameter int FRACTION_BITS = 8
) (
	input  logic clk,
	input  logic arst_n,
	lsgc_pix_if  pix,
	lsgc_res_if  res,
	lsgc_cfg_if  cfg,
	output int   fail_count,
	output int   centers_due
);
	import lsgc_pkg::*;

	localparam longint unsigned WEIGHT_SAT    = 64'h7FFF_FFFF;
	localparam longint unsigned INTENSITY_SAT = 64'h000F_FFFF;
	localparam longint unsigned CENTER_SAT    = 64'h0007_FFFF;

	typedef struct {
		logic [COL_W-1:0]    column;
		logic [CENTER_W-1:0] center;
	} stripe_center_t;

	logic [PIX_W-1:0]      pixel_thr;
	logic [SUMTHR_W-1:0]   sum_thr;
	logic [ROI_POS_W-1:0]  roi_left;
	logic [ROI_POS_W-1:0]  roi_top;
	logic [ROI_SIZE_W-1:0] roi_width;
	logic [ROI_SIZE_W-1:0] roi_height;

	longint unsigned row_weight_sum;
	longint unsigned intensity_sum;
	stripe_center_t  expected_centers[$];

	always @(posedge clk or negedge arst_n) begin
		stripe_center_t  want;
		longint unsigned center;
		int unsigned     row;
		int unsigned     col;
		logic            counted;
		if (!arst_n) begin
			pixel_thr = '0;
			sum_thr = '0;
			roi_left = '0;
			roi_top = '0;
			roi_width = '0;
			roi_height = '0;
			row_weight_sum = 0;
			intensity_sum = 0;
			expected_centers.delete();
			fail_count = 0;
			centers_due <= 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_PIXEL_THR:  pixel_thr = cfg.data[PIX_W-1:0];
					CFG_SUM_THR:    sum_thr = cfg.data[SUMTHR_W-1:0];
					CFG_ROI_LEFT:   roi_left = cfg.data[ROI_POS_W-1:0];
					CFG_ROI_TOP:    roi_top = cfg.data[ROI_POS_W-1:0];
					CFG_ROI_WIDTH:  roi_width = cfg.data[ROI_SIZE_W-1:0];
					CFG_ROI_HEIGHT: roi_height = cfg.data[ROI_SIZE_W-1:0];
					default: ;
				endcase
			end

			if (res.valid && res.ready) begin
				if (expected_centers.size() == 0) begin
					$error("center transfer with none expected: out_column %0d, center_row_fixed %0d",
						res.out_column, res.center_row_fixed);
					fail_count++;
				end else begin
					want = expected_centers.pop_front();
					if (res.out_column !== want.column) begin
						$error("out_column: expected %0d, actual %0d", want.column, res.out_column);
						fail_count++;
					end
					if (res.center_row_fixed !== want.center) begin
						$error("center_row_fixed: expected %0d, actual %0d",
							want.center, res.center_row_fixed);
						fail_count++;
					end
				end
			end

			if (pix.valid && pix.ready) begin
				row = pix.row_index;
				col = pix.column_index;
				// zero width or height selects the whole image
				counted = row < IMAGE_ROWS && col < IMAGE_COLS && pix.pixel_value >= pixel_thr &&
					(roi_width == 0 || roi_height == 0 ||
					(col >= roi_left && col < roi_left + roi_width &&
					row >= roi_top && row < roi_top + roi_height));
				if (counted) begin
					row_weight_sum = row_weight_sum + row * pix.pixel_value;
					if (row_weight_sum > WEIGHT_SAT)
						row_weight_sum = WEIGHT_SAT;
					intensity_sum = intensity_sum + pix.pixel_value;
					if (intensity_sum > INTENSITY_SAT)
						intensity_sum = INTENSITY_SAT;
				end
				if (pix.column_end) begin
					if (intensity_sum > sum_thr) begin
						center = (row_weight_sum << FRACTION_BITS) / intensity_sum;
						if (center > CENTER_SAT)
							center = CENTER_SAT;
						want.column = pix.column_index;
						want.center = center[CENTER_W-1:0];
						expected_centers.push_back(want);
					end
					row_weight_sum = 0;
					intensity_sum = 0;
				end
			end

			centers_due <= expected_centers.size();
		end
	end

endmodule

>>> verif/laser_stripe_gray_centroid_test.sv
`timescale 1ns / 1ps
// Top of the laser stripe gray centroid test: clock, reset, pixel stimulus,
// register writes and result back-pressure; checking is done by the checker module.
// Depends on lsgc_pkg, lsgc_ifs, the block and laser_stripe_gray_centroid_checker.
module laser_stripe_gray_centroid_test;
	import lsgc_pkg::*;

	localparam int IMAGE_ROWS    = 2048;
	localparam int IMAGE_COLS    = 2048;
	localparam int FRACTION_BITS = 8;
	localparam int SETTLE_CYCLES = 2 * (36 + FRACTION_BITS);
	localparam int HOLD_CYCLES   = 600;
	localparam int STALL_LIMIT   = 4000;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_PIXELS  = 190;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idling_t;

	typedef struct {
		logic [PIX_W-1:0]      pixel_thr;
		logic [SUMTHR_W-1:0]   sum_thr;
		logic [ROI_POS_W-1:0]  roi_left;
		logic [ROI_POS_W-1:0]  roi_top;
		logic [ROI_SIZE_W-1:0] roi_width;
		logic [ROI_SIZE_W-1:0] roi_height;
	} roi_setup_t;

	logic       clk;
	logic       arst_n;
	logic       hold_request;
	logic       hold_done;
	int         idle_pct;
	int         stall_pct;
	int         hold_left;
	int         quiet_cycles;
	int         pixels_sent;
	int         fail_count;
	int         centers_due;
	roi_setup_t setup;

	lsgc_pix_if pix_ch ();
	lsgc_res_if res_ch ();
	lsgc_cfg_if cfg_ch ();

	laser_stripe_gray_centroid #(
		.IMAGE_ROWS   (IMAGE_ROWS),
		.IMAGE_COLS   (IMAGE_COLS),
		.FRACTION_BITS(FRACTION_BITS)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.pix   (pix_ch),
		.res   (res_ch),
		.cfg   (cfg_ch)
	);

	laser_stripe_gray_centroid_checker #(
		.IMAGE_ROWS   (IMAGE_ROWS),
		.IMAGE_COLS   (IMAGE_COLS),
		.FRACTION_BITS(FRACTION_BITS)
	) i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix        (pix_ch),
		.res        (res_ch),
		.cfg        (cfg_ch),
		.fail_count (fail_count),
		.centers_due(centers_due)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// result side: one long hold-off on request, random stalls otherwise
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_request && !hold_done) begin
			res_ch.ready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			res_ch.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			res_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready) ||
			(cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic put_pixel(input logic [PIX_W-1:0] value, input logic [ROW_W-1:0] row,
		input logic [COL_W-1:0] col, input logic last);
		while ($urandom_range(0, 99) < idle_pct) begin
			pix_ch.valid <= 1'b0;
			@(posedge clk);
		end
		pix_ch.valid <= 1'b1;
		pix_ch.pixel_value <= value;
		pix_ch.row_index <= row;
		pix_ch.column_index <= col;
		pix_ch.column_end <= last;
		@(posedge clk);
		while (!pix_ch.ready)
			@(posedge clk);
		pixels_sent++;
	endtask

	// junk above the field width must be dropped by the block
	task automatic put_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_DATA_W-1:0] value,
		input int field_w);
		logic [CFG_DATA_W-1:0] junk;
		junk = CFG_DATA_W'($urandom) << field_w;
		if (field_w >= CFG_DATA_W || $urandom_range(0, 1) == 0)
			junk = '0;
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= index;
		cfg_ch.data <= value | junk;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
	endtask

	// stop offering pixels, wait out every center and the divider latency
	task automatic drain();
		pix_ch.valid <= 1'b0;
		@(posedge clk);
		while (centers_due != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apply_setup(input roi_setup_t s);
		drain();
		put_reg(CFG_SPARE_LO, CFG_DATA_W'($urandom), CFG_DATA_W);
		put_reg(CFG_SPARE_HI, CFG_DATA_W'($urandom), CFG_DATA_W);
		put_reg(CFG_PIXEL_THR, CFG_DATA_W'(s.pixel_thr), PIX_W);
		put_reg(CFG_SUM_THR, CFG_DATA_W'(s.sum_thr), SUMTHR_W);
		put_reg(CFG_ROI_LEFT, CFG_DATA_W'(s.roi_left), ROI_POS_W);
		put_reg(CFG_ROI_TOP, CFG_DATA_W'(s.roi_top), ROI_POS_W);
		put_reg(CFG_ROI_WIDTH, CFG_DATA_W'(s.roi_width), ROI_SIZE_W);
		put_reg(CFG_ROI_HEIGHT, CFG_DATA_W'(s.roi_height), ROI_SIZE_W);
		cfg_ch.valid <= 1'b0;
		setup = s;
	endtask

	function automatic roi_setup_t make_setup(input int pix_thr, input int sum_thr,
		input int left, input int top_row, input int wid, input int hgt);
		roi_setup_t s;
		s.pixel_thr = PIX_W'(pix_thr);
		s.sum_thr = SUMTHR_W'(sum_thr);
		s.roi_left = ROI_POS_W'(left);
		s.roi_top = ROI_POS_W'(top_row);
		s.roi_width = ROI_SIZE_W'(wid);
		s.roi_height = ROI_SIZE_W'(hgt);
		return s;
	endfunction

	initial begin
		roi_setup_t s;
		int         goal;
		int         rows;
		int         col;
		int         first;
		int         span;
		int         peak;
		int         amp;
		int         slope;
		int         lvl;
		logic       closed;
		arst_n <= 1'b0;
		pix_ch.valid <= 1'b0;
		pix_ch.pixel_value <= '0;
		pix_ch.row_index <= '0;
		pix_ch.column_index <= '0;
		pix_ch.column_end <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= CFG_PIXEL_THR;
		cfg_ch.data <= '0;
		stall_pct <= 0;
		hold_request <= 1'b0;
		idle_pct = 0;
		pixels_sent = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// whole image, no thresholds: field extremes, single-pixel and short columns
		apply_setup(make_setup(0, 0, 0, 0, 0, 0));
		put_pixel(8'd0, 11'd0, 11'd0, 1'b1);
		put_pixel(8'd255, 11'd2047, 11'd2047, 1'b1);
		put_pixel(8'd10, 11'd100, 11'd1365, 1'b0);
		put_pixel(8'd200, 11'd101, 11'd1365, 1'b0);
		put_pixel(8'd50, 11'd102, 11'd1365, 1'b1);
		put_pixel(8'd1, 11'd0, 11'd682, 1'b1);
		put_pixel(8'd255, 11'd1, 11'd1024, 1'b0);
		put_pixel(8'd255, 11'd2046, 11'd1024, 1'b1);
		put_pixel(8'h55, 11'h555, 11'h2AA, 1'b1);

		// region edges, pixel threshold and the sum threshold boundary
		apply_setup(make_setup(128, 383, 100, 500, 10, 20));
		put_pixel(8'd127, 11'd505, 11'd105, 1'b0);
		put_pixel(8'd128, 11'd506, 11'd105, 1'b0);
		put_pixel(8'd255, 11'd507, 11'd105, 1'b1);
		put_pixel(8'd129, 11'd505, 11'd106, 1'b0);
		put_pixel(8'd255, 11'd507, 11'd106, 1'b1);
		put_pixel(8'd255, 11'd510, 11'd99, 1'b1);
		put_pixel(8'd255, 11'd510, 11'd110, 1'b1);
		put_pixel(8'd255, 11'd499, 11'd100, 1'b1);
		put_pixel(8'd200, 11'd518, 11'd109, 1'b0);
		put_pixel(8'd200, 11'd519, 11'd109, 1'b0);
		put_pixel(8'd255, 11'd520, 11'd109, 1'b1);

		// zero width means the whole image despite a far-off corner
		apply_setup(make_setup(0, 0, 1500, 1500, 0, 7));
		put_pixel(8'd0, 11'd5, 11'd5, 1'b0);
		put_pixel(8'd0, 11'd6, 11'd5, 1'b1);
		put_pixel(8'd3, 11'd1000, 11'd2000, 1'b1);

		// register extremes and a region clipped at the image corner
		apply_setup(make_setup(255, 522240, 2047, 2047, 2048, 2048));
		put_pixel(8'd255, 11'd2047, 11'd2046, 1'b1);
		put_pixel(8'd254, 11'd2047, 11'd2047, 1'b1);
		put_pixel(8'd255, 11'd2047, 11'd2047, 1'b1);

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			s.pixel_thr = ($urandom_range(0, 4) == 0) ? PIX_W'($urandom) :
				PIX_W'($urandom_range(0, 40));
			case ($urandom_range(0, 9))
				0, 1, 2: s.sum_thr = '0;
				9:       s.sum_thr = SUMTHR_W'($urandom_range(0, 522240));
				default: s.sum_thr = SUMTHR_W'($urandom_range(0, 1500));
			endcase
			s.roi_left = ROI_POS_W'($urandom);
			s.roi_top = ROI_POS_W'($urandom);
			s.roi_width = ($urandom_range(0, 3) == 0) ? '0 : ROI_SIZE_W'($urandom_range(1, 2048));
			s.roi_height = ($urandom_range(0, 3) == 0) ? '0 : ROI_SIZE_W'($urandom_range(1, 2048));
			apply_setup(s);

			case (idling_t'(p % 4))
				IDLE_NONE: begin
					idle_pct = 0;
					stall_pct <= 0;
				end
				IDLE_SENDER: begin
					idle_pct = 71;
					stall_pct <= 0;
				end
				IDLE_RECEIVER: begin
					idle_pct = 0;
					stall_pct <= 71;
				end
				default: begin
					idle_pct = 8;
					stall_pct <= 8;
				end
			endcase
			// back the block up once: centers held off while pixels keep coming
			if (p == 0)
				hold_request <= 1'b1;

			goal = pixels_sent + PHASE_PIXELS;
			while (pixels_sent < goal) begin
				if ($urandom_range(0, 9) == 0) begin
					put_pixel(PIX_W'($urandom), ROW_W'($urandom), COL_W'($urandom),
						$urandom_range(0, 3) == 0);
				end else begin
					rows = ($urandom_range(0, 15) == 0) ? $urandom_range(16, 64) :
						$urandom_range(1, 12);
					col = $urandom_range(0, IMAGE_COLS - 1);
					first = $urandom_range(0, IMAGE_ROWS - rows);
					if (setup.roi_width != 0 && setup.roi_height != 0) begin
						span = setup.roi_width;
						if (setup.roi_left + span > IMAGE_COLS)
							span = IMAGE_COLS - setup.roi_left;
						case ($urandom_range(0, 9))
							0:             col = int'(setup.roi_left) - 1;
							1:             col = int'(setup.roi_left) + span;
							2, 3, 4, 5, 6: col = setup.roi_left + $urandom_range(0, span - 1);
							default: ;
						endcase
						if (col < 0 || col >= IMAGE_COLS)
							col = setup.roi_left;
						case ($urandom_range(0, 4))
							0, 1: first = int'(setup.roi_top) - int'($urandom_range(0, rows));
							2:    first = int'(setup.roi_top) + int'(setup.roi_height) -
								int'($urandom_range(0, rows));
							default: ;
						endcase
						if (first < 0)
							first = 0;
						if (first > IMAGE_ROWS - rows)
							first = IMAGE_ROWS - rows;
					end
					peak = $urandom_range(0, rows - 1);
					amp = $urandom_range(0, 255);
					slope = $urandom_range(8, 80);
					// an open stripe runs on into the next column
					closed = $urandom_range(0, 9) != 0;
					for (int k = 0; k < rows; k++) begin
						lvl = amp - slope * ((k > peak) ? k - peak : peak - k) +
							int'($urandom_range(0, 15));
						if (lvl < 0)
							lvl = 0;
						else if (lvl > 255)
							lvl = 255;
						put_pixel(PIX_W'(lvl), ROW_W'(first + k), COL_W'(col),
							closed && k == rows - 1);
					end
				end
			end
			// close the phase on a column end so the sums start clean
			put_pixel(PIX_W'($urandom), ROW_W'($urandom), COL_W'($urandom), 1'b1);
		end

		drain();
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
